// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // command codes
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_GET,
        S_SRC_CHK,
        S_SRC_CMP,
        S_RM_CHK,
        S_RM_WR,
        S_INS_CHK,
        S_INS_CMP,
        S_MIN_RD,
        S_MIN_GET,
        S_DONE
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_res_ctl;

endpackage

`default_nettype wire

// ----- sv/spq_mem.sv -----
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  wire                         i_clk,
    input  spq_pkg::t_mem_ctl           i_ctl,
    input  wire [$clog2(DEPTH)-1:0]     i_waddr,
    input  wire [WIDTH-1:0]             i_wdata,
    input  wire [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [WIDTH-1:0]            o_rdata
);
    import spq_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Command sequencer: search, shift-down removal and insertion sort over the
// entry store, then a read of the head for the minimum key.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl #(
    parameter int DEPTH     = 16,
    parameter int ID_WIDTH  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire [1:0]                           i_command,
    input  wire [ID_WIDTH-1:0]                  i_task_id,
    input  wire [KEY_WIDTH-1:0]                 i_key,
    output spq_pkg::t_res_ctl                   o_res,
    input  wire                                 i_res_take,
    output logic [ID_WIDTH-1:0]                 o_res_id,
    output logic [KEY_WIDTH-1:0]                o_res_key,
    output logic [KEY_WIDTH-1:0]                o_min_key,
    output logic [$clog2(DEPTH+1)-1:0]          o_count,
    output spq_pkg::t_mem_ctl                   o_mem_ctl,
    output logic [$clog2(DEPTH)-1:0]            o_mem_waddr,
    output logic [ID_WIDTH+KEY_WIDTH-1:0]       o_mem_wdata,
    output logic [$clog2(DEPTH)-1:0]            o_mem_raddr,
    input  wire [ID_WIDTH+KEY_WIDTH-1:0]        i_mem_rdata
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_idx, n_idx;
    logic [1:0]             r_cmd, n_cmd;
    logic [ID_WIDTH-1:0]    r_id, n_id;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    t_status                r_status, n_status;
    logic [ID_WIDTH-1:0]    r_res_id, n_res_id;
    logic [KEY_WIDTH-1:0]   r_res_key, n_res_key;
    logic [KEY_WIDTH-1:0]   r_min, n_min;

    logic [ID_WIDTH-1:0]    rd_id;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [CW-1:0]          idx_m1;
    logic                   at_end;
    logic                   rd_greater;
    logic                   id_match;

    assign rd_id      = i_mem_rdata[ID_WIDTH+KEY_WIDTH-1:KEY_WIDTH];
    assign rd_key     = i_mem_rdata[KEY_WIDTH-1:0];
    assign idx_m1     = r_idx - 1'b1;
    assign at_end     = (r_idx == r_count);
    assign rd_greater = ($signed(rd_key) > $signed(r_key));
    assign id_match   = (rd_id == r_id);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_PUSH:   n_state = (r_count == FULL_COUNT) ? S_MIN_RD : S_INS_CHK;
                        CMD_POP:    n_state = (r_count == '0) ? S_MIN_RD : S_POP_RD;
                        CMD_UPDATE: n_state = S_SRC_CHK;
                        default:    n_state = S_MIN_RD;
                    endcase
                end
            end
            S_POP_RD:  n_state = S_POP_GET;
            S_POP_GET: n_state = S_RM_CHK;
            S_SRC_CHK: n_state = at_end ? S_MIN_RD : S_SRC_CMP;
            S_SRC_CMP: n_state = id_match ? S_RM_CHK : S_SRC_CHK;
            S_RM_CHK: begin
                if (at_end) begin
                    n_state = (r_cmd == CMD_UPDATE) ? S_INS_CHK : S_MIN_RD;
                end else begin
                    n_state = S_RM_WR;
                end
            end
            S_RM_WR:   n_state = S_RM_CHK;
            S_INS_CHK: n_state = (r_idx == '0) ? S_MIN_RD : S_INS_CMP;
            S_INS_CMP: n_state = rd_greater ? S_INS_CHK : S_MIN_RD;
            S_MIN_RD:  n_state = S_MIN_GET;
            S_MIN_GET: n_state = S_DONE;
            S_DONE:    n_state = i_res_take ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        o_mem_ctl   = '0;
        o_mem_waddr = r_idx[AW-1:0];
        o_mem_wdata = {r_id, r_key};
        o_mem_raddr = r_idx[AW-1:0];
        o_in_stall  = (r_state != S_IDLE);
        o_res.valid  = (r_state == S_DONE);
        o_res.status = r_status;
        unique case (r_state)
            S_POP_RD: begin
                o_mem_ctl.re = 1'b1;
                o_mem_raddr  = '0;
            end
            S_SRC_CHK, S_RM_CHK: begin
                o_mem_ctl.re = !at_end;
            end
            S_RM_WR: begin
                // slide entry idx down to idx-1
                o_mem_ctl.we = 1'b1;
                o_mem_waddr  = idx_m1[AW-1:0];
                o_mem_wdata  = i_mem_rdata;
            end
            S_INS_CHK: begin
                if (r_idx == '0) begin
                    o_mem_ctl.we = 1'b1;
                    o_mem_waddr  = '0;
                end else begin
                    o_mem_ctl.re = 1'b1;
                    o_mem_raddr  = idx_m1[AW-1:0];
                end
            end
            S_INS_CMP: begin
                // larger key moves up one slot, else the new entry lands here
                o_mem_ctl.we = 1'b1;
                if (rd_greater) begin
                    o_mem_wdata = i_mem_rdata;
                end
            end
            S_MIN_RD: begin
                o_mem_ctl.re = 1'b1;
                o_mem_raddr  = '0;
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_id      = r_id;
        n_key     = r_key;
        n_status  = r_status;
        n_res_id  = r_res_id;
        n_res_key = r_res_key;
        n_min     = r_min;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = i_command;
                    n_id      = i_task_id;
                    n_key     = i_key;
                    n_status  = ST_OK;
                    n_res_id  = '0;
                    n_res_key = '0;
                    case (i_command)
                        CMD_PUSH: begin
                            n_idx = r_count;
                            if (r_count == FULL_COUNT) begin
                                n_status = ST_FULL;
                            end
                        end
                        CMD_POP: begin
                            n_idx = CW'(1);
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        default: n_idx = '0;
                    endcase
                end
            end
            S_POP_GET: n_res_id = rd_id;
            S_SRC_CHK: begin
                if (at_end) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            // on a match removal starts at the following slot
            S_SRC_CMP: n_idx = r_idx + 1'b1;
            S_RM_CHK: begin
                if (at_end) begin
                    n_count = r_count - 1'b1;
                    if (r_cmd == CMD_UPDATE) begin
                        n_idx     = r_count - 1'b1;
                        n_res_key = r_key;
                    end
                end
            end
            S_RM_WR: n_idx = r_idx + 1'b1;
            S_INS_CHK: begin
                if (r_idx == '0) begin
                    n_count = r_count + 1'b1;
                end
            end
            S_INS_CMP: begin
                if (rd_greater) begin
                    n_idx = idx_m1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            S_MIN_GET: n_min = (r_count != '0) ? rd_key : '0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmd     <= n_cmd;
        r_id      <= n_id;
        r_key     <= n_key;
        r_status  <= n_status;
        r_res_id  <= n_res_id;
        r_res_key <= n_res_key;
        r_min     <= n_min;
    end

    assign o_res_id  = r_res_id;
    assign o_res_key = r_res_key;
    assign o_min_key = r_min;
    assign o_count   = r_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("occupancy above depth");

    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.we && o_mem_ctl.re))
        else $error("read and write issued together");

    // removal shifts run with the count still at its old value, even when full
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.we |-> (r_idx <= r_count) &&
            ((r_state == S_RM_WR) || (r_count != FULL_COUNT)))
        else $error("write outside occupied range");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_FULL) |-> (r_count == FULL_COUNT))
        else $error("full reported below depth");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty reported with entries held");

endmodule

`default_nettype wire

// ----- sv/sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Sorted priority queue with push, pop-minimum and key update.
//
//  channel   direction  handshake                 payload
//  command   in         i_in_valid / o_in_stall   i_command, i_task_id, i_key
//  result    out        o_out_valid / i_out_stall o_status, o_out_id, o_out_key,
//                                                 o_min_key, o_empty_flag,
//                                                 o_occupancy
//
//  One command at a time. A command reads or writes one entry at a time in
//  the entry store, never both at once: a push compares and moves one entry
//  at a time, a pop shifts all others down, an update searches, shifts and
//  reinserts.
//  Reset empties the queue at once; store contents need no clearing.
//  The result register lets the next command start while a result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int ID_WIDTH  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [1:0]                       i_command,
    input  wire [ID_WIDTH-1:0]              i_task_id,
    input  wire [KEY_WIDTH-1:0]             i_key,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [1:0]                      o_status,
    output logic [ID_WIDTH-1:0]             o_out_id,
    output logic [KEY_WIDTH-1:0]            o_out_key,
    output logic [KEY_WIDTH-1:0]            o_min_key,
    output logic                            o_empty_flag,
    output logic [$clog2(DEPTH+1)-1:0]      o_occupancy
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = ID_WIDTH + KEY_WIDTH;

    t_mem_ctl               mem_ctl;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          mem_raddr;
    logic [DW-1:0]          mem_wdata;
    logic [DW-1:0]          mem_rdata;

    t_res_ctl               res;
    logic                   res_take;
    logic [ID_WIDTH-1:0]    res_id;
    logic [KEY_WIDTH-1:0]   res_key;
    logic [KEY_WIDTH-1:0]   res_min;
    logic [CW-1:0]          res_count;

    logic                   r_out_valid, n_out_valid;
    logic [1:0]             r_status;
    logic [ID_WIDTH-1:0]    r_out_id;
    logic [KEY_WIDTH-1:0]   r_out_key;
    logic [KEY_WIDTH-1:0]   r_min_key;
    logic                   r_empty;
    logic [CW-1:0]          r_occ;

    spq_ctrl #(
        .DEPTH     (DEPTH),
        .ID_WIDTH  (ID_WIDTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_task_id   (i_task_id),
        .i_key       (i_key),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_res_id    (res_id),
        .o_res_key   (res_key),
        .o_min_key   (res_min),
        .o_count     (res_count),
        .o_mem_ctl   (mem_ctl),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    spq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // result register loads when empty or being drained this cycle
    assign res_take = res.valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_status  <= res.status;
            r_out_id  <= res_id;
            r_out_key <= res_key;
            r_min_key <= res_min;
            r_empty   <= (res_count == '0);
            r_occ     <= res_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_out_id     = r_out_id;
    assign o_out_key    = r_out_key;
    assign o_min_key    = r_min_key;
    assign o_empty_flag = r_empty;
    assign o_occupancy  = r_occ;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for sorted_priority_queue_unit. A short directed table covers
// the empty, full and not-found cases, extreme keys and identifiers, ties
// and the unused command. Weighted random command streams then fill and
// drain the queue many times. Results are checked against table values
// or a cycle-free model of the sorted queue. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb;
    import spq_pkg::*;

    localparam int          DEPTH       = 16;
    localparam int          CLK_HALF    = 4;
    localparam int          RAND_ITEMS  = 1850;
    localparam int          DRAIN_WAIT  = 120;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam logic [1:0]  CMD_NOP     = 2'd3;     // unused code, leaves the queue unchanged

    typedef struct packed {
        t_status      status;
        logic [15:0]  out_id;
        logic [31:0]  out_key;
        logic [31:0]  min_key;
        logic         empty_flag;
        logic [4:0]   occupancy;
    } queue_result_t;

    typedef struct packed {
        logic [1:0]     cmd;
        logic [15:0]    id;
        logic [31:0]    key;
        int             reps;       // repeated rows bump id by 1 and key by key_step
        int             key_step;
        bit             typed;
        queue_result_t  res;
    } stim_row_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [1:0]  i_command   = CMD_NOP;
    logic [15:0] i_task_id   = '0;
    logic [31:0] i_key       = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [15:0] o_out_id;
    logic [31:0] o_out_key;
    logic [31:0] o_min_key;
    logic        o_empty_flag;
    logic [4:0]  o_occupancy;

    sorted_priority_queue_unit #(
        .DEPTH     (DEPTH),
        .ID_WIDTH  (16),
        .KEY_WIDTH (32)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_task_id    (i_task_id),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_out_id     (o_out_id),
        .o_out_key    (o_out_key),
        .o_min_key    (o_min_key),
        .o_empty_flag (o_empty_flag),
        .o_occupancy  (o_occupancy)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ---------------- queue model ----------------
    logic [15:0]        q_ids  [DEPTH];
    logic signed [31:0] q_keys [DEPTH];
    int                 q_count;

    queue_result_t expected_results[$];

    int errors_seen;
    int results_checked;
    int cycles;
    int n_push, n_pop, n_update, n_other, n_full, n_empty, n_missing;

    function automatic void q_insert(logic [15:0] id, logic signed [31:0] key);
        int pos;
        pos = q_count;
        // ties: new entry lands after every equal key
        while (pos > 0 && q_keys[pos-1] > key) begin
            q_ids[pos]  = q_ids[pos-1];
            q_keys[pos] = q_keys[pos-1];
            pos--;
        end
        q_ids[pos]  = id;
        q_keys[pos] = key;
        q_count++;
    endfunction

    function automatic void q_remove(int pos);
        for (int i = pos + 1; i < q_count; i++) begin
            q_ids[i-1]  = q_ids[i];
            q_keys[i-1] = q_keys[i];
        end
        q_count--;
    endfunction

    function automatic queue_result_t apply_queue_cmd(logic [1:0] cmd, logic [15:0] id,
                                                      logic [31:0] key);
        queue_result_t r;
        int            idx;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                n_push++;
                if (q_count >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    q_insert(id, key);
                end
            end
            CMD_POP: begin
                n_pop++;
                if (q_count == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    r.out_id = q_ids[0];
                    q_remove(0);
                end
            end
            CMD_UPDATE: begin
                n_update++;
                idx = 0;
                while (idx < q_count && q_ids[idx] != id) idx++;
                if (idx >= q_count) begin
                    r.status = ST_NOT_FOUND;
                    n_missing++;
                end else begin
                    q_remove(idx);
                    q_insert(id, key);
                    r.out_key = key;
                end
            end
            default: n_other++;
        endcase
        r.min_key    = (q_count > 0) ? q_keys[0] : '0;
        r.empty_flag = (q_count == 0);
        r.occupancy  = q_count[4:0];
        return r;
    endfunction

    // ---------------- result checking ----------------
    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            errors_seen++;
        end
    endtask

    always @(posedge i_clk) begin
        queue_result_t exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected (status %0d)", o_status);
                errors_seen++;
            end else begin
                exp_res = expected_results.pop_front();
                results_checked++;
                check_field("status", exp_res.status, o_status);
                check_field("out_id", exp_res.out_id, o_out_id);
                check_field("out_key", exp_res.out_key, o_out_key);
                check_field("min_key", exp_res.min_key, o_min_key);
                check_field("empty_flag", exp_res.empty_flag, o_empty_flag);
                check_field("occupancy", exp_res.occupancy, o_occupancy);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- result-side stall pattern ----------------
    int rx_count;
    int rx_mode;

    always @(negedge i_clk) begin
        rx_count <= rx_count + 1;
        if (rx_count % 48 == 0)
            rx_mode <= $urandom_range(0, 3);
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 9) < 3);
                2: i_out_stall <= ($urandom_range(0, 9) < 7);
                default: i_out_stall <= (rx_count % 5 < 2);
            endcase
        end
    end

    // ---------------- command driver ----------------
    int burst_left;

    task automatic drive_cmd(logic [1:0] cmd, logic [15:0] id, logic [31:0] key,
                             bit typed, queue_result_t typed_res);
        queue_result_t r;
        int            gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_task_id  <= id;
        i_key      <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // transfer accepted at this edge
        r = apply_queue_cmd(cmd, id, key);
        expected_results.push_back(typed ? typed_res : r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_command  <= 2'($urandom);
            i_task_id  <= 16'($urandom);
            i_key      <= $urandom;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'($urandom_range(0, 16)) - 32'd8;   // dense ties
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_id();
        if ($urandom_range(0, 9) < 7)
            return 16'($urandom_range(0, 31));
        return 16'($urandom_range(0, 65535));
    endfunction

    stim_row_t dir_rows[$];

    initial begin
        stim_row_t    row;
        logic [1:0]   cmd;
        logic [15:0]  id;
        int           pick;
        int           push_w;
        int           pop_w;

        dir_rows = '{
            '{CMD_POP,    16'h0000, 32'h0000_0000, 1, 0, 1'b1,
              '{ST_EMPTY, 16'h0, 32'h0, 32'h0, 1'b1, 5'd0}},
            '{CMD_UPDATE, 16'h0005, 32'h0000_0011, 1, 0, 1'b1,
              '{ST_NOT_FOUND, 16'h0, 32'h0, 32'h0, 1'b1, 5'd0}},
            '{CMD_NOP,    16'hFFFF, 32'hFFFF_FFFF, 1, 0, 1'b1,
              '{ST_OK, 16'h0, 32'h0, 32'h0, 1'b1, 5'd0}},
            '{CMD_PUSH,   16'hFFFF, 32'h7FFF_FFFF, 1, 0, 1'b1,
              '{ST_OK, 16'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, 5'd1}},
            '{CMD_PUSH,   16'h0000, 32'h8000_0000, 1, 0, 1'b1,
              '{ST_OK, 16'h0, 32'h0, 32'h8000_0000, 1'b0, 5'd2}},
            '{CMD_PUSH,   16'h0001, 32'h0000_0000, 1, 0, 1'b0, '0},
            '{CMD_PUSH,   16'h0002, 32'h0000_0000, 1, 0, 1'b0, '0},
            // equal key: id 1 moves behind id 2
            '{CMD_UPDATE, 16'h0001, 32'h0000_0000, 1, 0, 1'b0, '0},
            '{CMD_UPDATE, 16'hFFFF, 32'h8000_0000, 1, 0, 1'b0, '0},
            '{CMD_UPDATE, 16'h1234, 32'h0000_0042, 1, 0, 1'b1,
              '{ST_NOT_FOUND, 16'h0, 32'h0, 32'h8000_0000, 1'b0, 5'd4}},
            '{CMD_POP,    16'h5555, 32'h0000_0000, 1, 0, 1'b0, '0},
            // fill with falling keys so each push lands ahead of the last
            '{CMD_PUSH,   16'h0100, 32'h0000_03E8, 13, -100, 1'b0, '0},
            '{CMD_PUSH,   16'hAAAA, 32'h5555_5555, 1, 0, 1'b1,
              '{ST_FULL, 16'h0, 32'h0, 32'h8000_0000, 1'b0, 5'd16}},
            '{CMD_UPDATE, 16'h0002, 32'h8000_0000, 1, 0, 1'b0, '0},
            '{CMD_POP,    16'h0000, 32'h0000_0000, 1, 0, 1'b0, '0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            for (int n = 0; n < row.reps; n++)
                drive_cmd(row.cmd, row.id + 16'(n), row.key + 32'(n * row.key_step),
                          row.typed, row.res);
        end

        // phases: balanced, push-heavy (fills), pop-heavy (drains)
        for (int n = 0; n < RAND_ITEMS; n++) begin
            case ((n / 150) % 3)
                0: begin push_w = 40; pop_w = 30; end
                1: begin push_w = 65; pop_w = 12; end
                default: begin push_w = 15; pop_w = 60; end
            endcase
            pick = $urandom_range(0, 99);
            id   = rand_id();
            if (pick < 4)
                cmd = CMD_NOP;
            else if (pick < 4 + push_w)
                cmd = CMD_PUSH;
            else if (pick < 4 + push_w + pop_w)
                cmd = CMD_POP;
            else begin
                cmd = CMD_UPDATE;
                if (q_count > 0 && $urandom_range(0, 9) < 8)
                    id = q_ids[$urandom_range(0, q_count - 1)];
            end
            drive_cmd(cmd, id, rand_key(), 1'b0, '0);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d results: %0d push, %0d pop, %0d update, %0d unused command",
                 results_checked, n_push, n_pop, n_update, n_other);
        $display("Push on full %0d times, pop on empty %0d times, update miss %0d times",
                 n_full, n_empty, n_missing);
        if (errors_seen == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/spq_pkg.sv
sv/spq_mem.sv
sv/spq_ctrl.sv
sv/sorted_priority_queue_unit.sv
verif/tb.sv
